### hdl/generational_handle_allocator_assert.svh
// Assertion macros for the generational handle allocator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define GHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/gha_pkg.sv
// Shared types and constants of the generational handle allocator.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package gha_pkg;

  localparam int unsigned MAX_SLOTS   = 1024;
  localparam int unsigned GEN_BITS    = 16;
  localparam int unsigned TYPE_BITS   = 8;
  localparam int unsigned IDX_BITS    = $clog2(MAX_SLOTS);
  localparam int unsigned HANDLE_BITS = IDX_BITS + GEN_BITS;
  localparam int unsigned CNT_BITS    = $clog2(MAX_SLOTS + 1);

  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [GEN_BITS-1:0]    gen_t;
  typedef logic [TYPE_BITS-1:0]   etype_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  typedef struct packed {
    gen_t   gen;
    logic   deleted;
    etype_t etype;
  } slot_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_EOF    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_QFULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_DELETE,
    S_LOOKUP,
    S_EOF_RDS,
    S_EOF_CHK,
    S_EOF_FIN
  } state_e;

  function automatic idx_t hdl_idx(handle_t h);
    return h[IDX_BITS-1:0];
  endfunction

  function automatic gen_t hdl_gen(handle_t h);
    return h[HANDLE_BITS-1:IDX_BITS];
  endfunction

endpackage

### hdl/gha_req_if.sv
// Request channel of the generational handle allocator: valid/ready plus one item.
// Depends on gha_pkg.
`timescale 1ns / 1ps

interface gha_req_if;
  logic                 valid;
  logic                 ready;
  gha_pkg::op_e         operation;
  gha_pkg::handle_t     handle;
  gha_pkg::etype_t      type_code;

  modport source (output valid, output operation, output handle, output type_code,
                  input ready);
  modport sink   (input valid, input operation, input handle, input type_code,
                  output ready);
endinterface

### hdl/gha_rsp_if.sv
// Response channel of the generational handle allocator: valid/ready plus one item.
// Depends on gha_pkg.
`timescale 1ns / 1ps

interface gha_rsp_if;
  logic                 valid;
  logic                 ready;
  gha_pkg::status_e     status;
  gha_pkg::handle_t     result_handle;
  gha_pkg::etype_t      result_type;
  gha_pkg::cnt_t        freed_count;

  modport source (output valid, output status, output result_handle, output result_type,
                  output freed_count, input ready);
  modport sink   (input valid, input status, input result_handle, input result_type,
                  input freed_count, output ready);
endinterface

### hdl/generational_handle_allocator.sv
// Top level of the generational handle allocator: control FSM, slot table,
// free stack and delete queue. Depends on gha_pkg, gha_req_if, gha_rsp_if.
`timescale 1ns / 1ps

// Generational handle allocator. A handle is a slot index (low bits) and a
// generation (high bits); slot 0 is the nil entry and is never handed out.
// Allocate pops the most recently freed handle and bumps its generation, or
// takes the next fresh slot with generation 1, or answers "table full".
// Delete only queues the handle; end of frame walks the queue in order and
// frees every queued handle that is still valid (invalid or duplicate ones
// are skipped). Lookup checks a handle and returns its stored type.
// One item at a time. Allocate, delete and lookup are accepted in idle and then
// finish in their own working state; every memory has registered read data that
// arrives in the cycle after the address. End of frame walks the queued handles
// in turn: each entry needs a queue read followed by a dependent slot-table read
// (S_EOF_RDS, then S_EOF_CHK), and the walk is set by that chain. A new item is
// taken while the previous result still waits in the output register; the FSM
// stalls only when it must load a result and that register is still full.
// No memory is cleared after reset; unwritten entries are never used.
module generational_handle_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  gha_req_if.sink    req_i,
  gha_rsp_if.source  rsp_o
);

  `include "generational_handle_allocator_assert.svh"

  // ---------------------------------------------------------------------
  // Control state and counters
  // ---------------------------------------------------------------------
  gha_pkg::state_e  state_q, state_d;
  gha_pkg::cnt_t    siu_q, siu_d;        // slots in use, nil slot included
  gha_pkg::cnt_t    fs_cnt_q, fs_cnt_d;  // free stack fill
  gha_pkg::cnt_t    dq_cnt_q, dq_cnt_d;  // delete queue fill
  gha_pkg::cnt_t    walk_q, walk_d;      // end-of-frame queue position
  gha_pkg::cnt_t    freed_q, freed_d;    // handles freed in this walk

  // Latched request payload
  gha_pkg::handle_t hdl_q;
  gha_pkg::etype_t  etype_q;

  // ---------------------------------------------------------------------
  // Memories: slot table, free stack, delete queue
  // ---------------------------------------------------------------------
  gha_pkg::slot_t   slot_mem [gha_pkg::MAX_SLOTS];
  gha_pkg::handle_t fs_mem   [gha_pkg::MAX_SLOTS];
  gha_pkg::handle_t dq_mem   [gha_pkg::MAX_SLOTS];

  logic             slot_we, slot_re;
  gha_pkg::idx_t    slot_waddr, slot_raddr;
  gha_pkg::slot_t   slot_wdata, slot_rd_q;

  logic             fs_we, fs_re;
  gha_pkg::idx_t    fs_waddr, fs_raddr;
  gha_pkg::handle_t fs_wdata, fs_rd_q;

  logic             dq_we, dq_re;
  gha_pkg::idx_t    dq_waddr, dq_raddr;
  gha_pkg::handle_t dq_wdata, dq_rd_q;

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic             out_valid_q;
  gha_pkg::status_e out_status_q, out_status_d;
  gha_pkg::handle_t out_hdl_q, out_hdl_d;
  gha_pkg::etype_t  out_type_q, out_type_d;
  gha_pkg::cnt_t    out_freed_q, out_freed_d;
  logic             out_load;

  logic             accept;
  logic             out_free;
  gha_pkg::cnt_t    fs_top;
  gha_pkg::cnt_t    walk_nxt;
  logic             lookup_ok;
  logic             walk_ok;

  // Handle is live: index inside the used range, generation nonzero,
  // generation matches the table and the slot is not marked deleted.
  function automatic logic hdl_ok(gha_pkg::handle_t h, gha_pkg::slot_t s,
                                  gha_pkg::cnt_t siu);
    gha_pkg::idx_t idx;
    gha_pkg::gen_t gen;
    idx = gha_pkg::hdl_idx(h);
    gen = gha_pkg::hdl_gen(h);
    return (idx != '0) && (gha_pkg::cnt_t'(idx) < siu) && (gen != '0) &&
           (s.gen == gen) && !s.deleted;
  endfunction

  assign req_i.ready = (state_q == gha_pkg::S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign fs_top      = fs_cnt_q - gha_pkg::cnt_t'(1);
  assign walk_nxt    = walk_q + gha_pkg::cnt_t'(1);
  assign lookup_ok   = hdl_ok(hdl_q, slot_rd_q, siu_q);
  assign walk_ok     = hdl_ok(dq_rd_q, slot_rd_q, siu_q);

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gha_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_i.operation)
            gha_pkg::OP_ALLOC:  state_d = gha_pkg::S_ALLOC;
            gha_pkg::OP_DELETE: state_d = gha_pkg::S_DELETE;
            gha_pkg::OP_LOOKUP: state_d = gha_pkg::S_LOOKUP;
            gha_pkg::OP_EOF: begin
              state_d = (dq_cnt_q != '0) ? gha_pkg::S_EOF_RDS : gha_pkg::S_EOF_FIN;
            end
            default: state_d = gha_pkg::S_IDLE;
          endcase
        end
      end
      gha_pkg::S_ALLOC,
      gha_pkg::S_DELETE,
      gha_pkg::S_LOOKUP,
      gha_pkg::S_EOF_FIN: begin
        if (out_free) begin
          state_d = gha_pkg::S_IDLE;
        end
      end
      gha_pkg::S_EOF_RDS: state_d = gha_pkg::S_EOF_CHK;
      gha_pkg::S_EOF_CHK: begin
        state_d = (walk_nxt < dq_cnt_q) ? gha_pkg::S_EOF_RDS : gha_pkg::S_EOF_FIN;
      end
      default: state_d = gha_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Memory accesses, counters and result
  // ---------------------------------------------------------------------
  always_comb begin
    siu_d        = siu_q;
    fs_cnt_d     = fs_cnt_q;
    dq_cnt_d     = dq_cnt_q;
    walk_d       = walk_q;
    freed_d      = freed_q;

    slot_we      = 1'b0;
    slot_waddr   = '0;
    slot_wdata   = slot_rd_q;
    slot_re      = 1'b0;
    slot_raddr   = '0;
    fs_we        = 1'b0;
    fs_waddr     = fs_cnt_q[gha_pkg::IDX_BITS-1:0];
    fs_wdata     = dq_rd_q;
    fs_re        = 1'b0;
    fs_raddr     = fs_top[gha_pkg::IDX_BITS-1:0];
    dq_we        = 1'b0;
    dq_waddr     = dq_cnt_q[gha_pkg::IDX_BITS-1:0];
    dq_wdata     = hdl_q;
    dq_re        = 1'b0;
    dq_raddr     = '0;

    out_load     = 1'b0;
    out_status_d = gha_pkg::ST_OK;
    out_hdl_d    = '0;
    out_type_d   = '0;
    out_freed_d  = '0;

    unique case (state_q)
      gha_pkg::S_IDLE: begin
        // Issue the read that the operation needs next cycle
        if (accept) begin
          unique case (req_i.operation)
            gha_pkg::OP_ALLOC:  fs_re = (fs_cnt_q != '0);
            gha_pkg::OP_LOOKUP: begin
              slot_re    = 1'b1;
              slot_raddr = gha_pkg::hdl_idx(req_i.handle);
            end
            gha_pkg::OP_EOF: begin
              dq_re    = (dq_cnt_q != '0);
              dq_raddr = '0;
              walk_d   = '0;
              freed_d  = '0;
            end
            default: ;
          endcase
        end
      end

      gha_pkg::S_ALLOC: begin
        if (out_free) begin
          out_load = 1'b1;
          if (fs_cnt_q != '0) begin
            // Reuse the most recently freed handle, next generation
            slot_we         = 1'b1;
            slot_waddr      = gha_pkg::hdl_idx(fs_rd_q);
            slot_wdata.gen  = gha_pkg::hdl_gen(fs_rd_q) + gha_pkg::gen_t'(1);
            fs_cnt_d        = fs_top;
          end else if (siu_q < gha_pkg::cnt_t'(gha_pkg::MAX_SLOTS)) begin
            // Fresh slot, generation 1
            slot_we         = 1'b1;
            slot_waddr      = siu_q[gha_pkg::IDX_BITS-1:0];
            slot_wdata.gen  = gha_pkg::gen_t'(1);
            siu_d           = siu_q + gha_pkg::cnt_t'(1);
          end else begin
            out_status_d    = gha_pkg::ST_FULL;
          end
          slot_wdata.deleted = 1'b0;
          slot_wdata.etype   = etype_q;
          if (slot_we) begin
            out_hdl_d = {slot_wdata.gen, slot_waddr};
          end
        end
      end

      gha_pkg::S_DELETE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (dq_cnt_q < gha_pkg::cnt_t'(gha_pkg::MAX_SLOTS)) begin
            dq_we    = 1'b1;
            dq_cnt_d = dq_cnt_q + gha_pkg::cnt_t'(1);
          end else begin
            out_status_d = gha_pkg::ST_QFULL;
          end
        end
      end

      gha_pkg::S_LOOKUP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (lookup_ok) begin
            out_hdl_d  = hdl_q;
            out_type_d = slot_rd_q.etype;
          end else begin
            out_status_d = gha_pkg::ST_INVALID;
          end
        end
      end

      gha_pkg::S_EOF_RDS: begin
        // Queue entry is in; fetch its slot
        slot_re    = 1'b1;
        slot_raddr = gha_pkg::hdl_idx(dq_rd_q);
      end

      gha_pkg::S_EOF_CHK: begin
        if (walk_ok) begin
          // Mark deleted, push onto the free stack
          slot_we            = 1'b1;
          slot_waddr         = gha_pkg::hdl_idx(dq_rd_q);
          slot_wdata.deleted = 1'b1;
          if (fs_cnt_q < gha_pkg::cnt_t'(gha_pkg::MAX_SLOTS)) begin
            fs_we    = 1'b1;
            fs_cnt_d = fs_cnt_q + gha_pkg::cnt_t'(1);
          end
          freed_d = freed_q + gha_pkg::cnt_t'(1);
        end
        // Advance to the next queued handle
        if (walk_nxt < dq_cnt_q) begin
          dq_re    = 1'b1;
          dq_raddr = walk_nxt[gha_pkg::IDX_BITS-1:0];
          walk_d   = walk_nxt;
        end
      end

      gha_pkg::S_EOF_FIN: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_freed_d = freed_q;
          dq_cnt_d    = '0;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gha_pkg::S_IDLE;
      siu_q    <= gha_pkg::cnt_t'(1);
      fs_cnt_q <= '0;
      dq_cnt_q <= '0;
      walk_q   <= '0;
      freed_q  <= '0;
    end else begin
      state_q  <= state_d;
      siu_q    <= siu_d;
      fs_cnt_q <= fs_cnt_d;
      dq_cnt_q <= dq_cnt_d;
      walk_q   <= walk_d;
      freed_q  <= freed_d;
    end
  end

  // Hold the request payload for the working cycles
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdl_q   <= req_i.handle;
      etype_q <= req_i.type_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_hdl_q    <= out_hdl_d;
      out_type_q   <= out_type_d;
      out_freed_q  <= out_freed_d;
    end
  end

  // Memories with registered read data
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_rd_q <= fs_mem[fs_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dq_we) begin
      dq_mem[dq_waddr] <= dq_wdata;
    end
    if (dq_re) begin
      dq_rd_q <= dq_mem[dq_raddr];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.result_handle = out_hdl_q;
  assign rsp_o.result_type   = out_type_q;
  assign rsp_o.freed_count   = out_freed_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `GHA_ASSERT(a_siu_range, clk_i, rst_ni,
              (siu_q != '0) && (siu_q <= gha_pkg::cnt_t'(gha_pkg::MAX_SLOTS)),
              "slots in use out of range")
  `GHA_ASSERT(a_fs_below_siu, clk_i, rst_ni, fs_cnt_q < siu_q,
              "free stack holds more handles than live slots")
  `GHA_ASSERT(a_walk_in_queue, clk_i, rst_ni,
              (state_q != gha_pkg::S_EOF_CHK) || (walk_q < dq_cnt_q),
              "end-of-frame walk beyond queue fill")
  `GHA_ASSERT(a_no_overwrite, clk_i, rst_ni, !(out_load && out_valid_q) || rsp_o.ready,
              "result register overwritten while full")
  `GHA_ASSERT_NEXT(a_queue_cleared, clk_i, rst_ni,
                   (state_q == gha_pkg::S_EOF_FIN) && out_free, dq_cnt_q == '0,
                   "delete queue not emptied after end of frame")

endmodule
